// ===== src/swaa_pkg.sv =====
// Shared types, widths and codes for the sensor window average alarm block.
package swaa_pkg;

    localparam int ID_W   = 16;
    localparam int TEMP_W = 16;
    localparam int TS_W   = 32;
    localparam int SUM_W  = 21;
    localparam int CNT_W  = 5;
    localparam int PROD_W = TEMP_W + CNT_W + 1;
    localparam int HELD_W = 3;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic REG_MIN_TEMP = 1'b0;
    localparam logic REG_MAX_TEMP = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic                     vld;
        logic                     cmd;
        logic                     done;
        logic [ID_W-1:0]          sid;
        logic [ID_W-1:0]          rid;
        logic signed [TEMP_W-1:0] temp;
        logic [TS_W-1:0]          ts;
        logic [ID_W-1:0]          room;
        logic signed [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]         cnt;
        logic [TS_W-1:0]          newest;
    } pkt_t;

    function automatic logic signed [SUM_W-1:0] sext_sum(input logic signed [TEMP_W-1:0] v);
        sext_sum = {{(SUM_W-TEMP_W){v[TEMP_W-1]}}, v};
    endfunction

endpackage

// ===== src/sensor_window_average_alarm_core.sv =====
// Top level: sensor map chain, mean divider, limit compare and result register.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   input     | in_valid / in_stall   | cmd sensor room_id temperature timestamp
//   result    | out_valid / out_stall | status room average samples_held too_cold
//             |                       | too_hot latest_time
//   config    | cfg_valid / cfg_ready | cfg_index cfg_data
//
// One item at a time: the item crosses the MAX_SENSORS cells in order (the first on the
// accepting edge), the chain tail starts the divider, 21 divide steps follow and the mean
// is latched, then out_valid rises; the next item is accepted only once the result has
// been taken.
// Reset clears every table entry's valid bit, count and newest time at once.
// in_stall stays high from acceptance until the result has been taken; out_stall holds it.
module sensor_window_average_alarm_core #(
    parameter int MAX_SENSORS = 16,
    parameter int WINDOW      = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [swaa_pkg::ID_W-1:0]          sensor,
    input  logic [swaa_pkg::ID_W-1:0]          room_id,
    input  logic signed [swaa_pkg::TEMP_W-1:0] temperature,
    input  logic [swaa_pkg::TS_W-1:0]          timestamp,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [swaa_pkg::ID_W-1:0]          room,
    output logic signed [swaa_pkg::TEMP_W-1:0] average,
    output logic [swaa_pkg::HELD_W-1:0]        samples_held,
    output logic                               too_cold,
    output logic                               too_hot,
    output logic [swaa_pkg::TS_W-1:0]          latest_time,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [swaa_pkg::TEMP_W-1:0]        cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_CHAIN, S_DIV, S_OUT} state_t;

    state_t                                state_reg;
    logic signed [swaa_pkg::TEMP_W-1:0]    min_temp_reg;
    logic signed [swaa_pkg::TEMP_W-1:0]    max_temp_reg;
    logic [1:0]                            status_reg;
    logic [swaa_pkg::ID_W-1:0]             room_reg;
    logic signed [swaa_pkg::TEMP_W-1:0]    average_reg;
    logic [swaa_pkg::HELD_W-1:0]           held_reg;
    logic                                  cold_reg;
    logic                                  hot_reg;
    logic [swaa_pkg::TS_W-1:0]             latest_reg;
    logic                                  mask_reg;

    swaa_pkg::pkt_t                        chain [MAX_SENSORS+1];
    logic [MAX_SENSORS-1:0]                chain_vld;
    swaa_pkg::pkt_t                        tail;
    logic                                  accept;
    logic                                  found;
    logic                                  smp_ok;
    logic signed [swaa_pkg::PROD_W-1:0]    min_prod;
    logic signed [swaa_pkg::PROD_W-1:0]    max_prod;
    logic signed [swaa_pkg::PROD_W-1:0]    sum_x;
    logic signed [swaa_pkg::CNT_W:0]       cnt_s;
    logic                                  div_start;
    logic                                  div_done;
    logic signed [swaa_pkg::TEMP_W-1:0]    div_q;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        chain[0]        = '0;
        chain[0].vld    = accept;
        chain[0].cmd    = cmd;
        chain[0].sid    = sensor;
        chain[0].rid    = room_id;
        chain[0].temp   = temperature;
        chain[0].ts     = timestamp;
    end

    for (genvar i = 0; i < MAX_SENSORS; i++) begin : g_cell
        swaa_cell #(.WINDOW(WINDOW)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .pkt_in  (chain[i]),
            .pkt_out (chain[i+1])
        );
        assign chain_vld[i] = chain[i+1].vld;
    end

    assign tail      = chain[MAX_SENSORS];
    assign found     = tail.done;
    assign smp_ok    = found && (tail.cmd == swaa_pkg::CMD_SAMPLE);
    assign cnt_s     = $signed({1'b0, tail.cnt});
    assign min_prod  = min_temp_reg * cnt_s;
    assign max_prod  = max_temp_reg * cnt_s;
    assign sum_x     = {{(swaa_pkg::PROD_W-swaa_pkg::SUM_W){tail.sum[swaa_pkg::SUM_W-1]}},
                        tail.sum};
    assign div_start = (state_reg == S_CHAIN) && tail.vld;

    swaa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tail.sum),
        .divisor  (tail.cnt),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            min_temp_reg <= '0;
            max_temp_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    swaa_pkg::REG_MIN_TEMP: min_temp_reg <= cfg_data;
                    swaa_pkg::REG_MAX_TEMP: max_temp_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:  if (accept) state_reg <= S_CHAIN;
                S_CHAIN: if (tail.vld) state_reg <= S_DIV;
                S_DIV:   if (div_done) state_reg <= S_OUT;
                S_OUT:   if (!out_stall) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // hold the result fields; the mean arrives last from the divider
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            status_reg <= found ? swaa_pkg::ST_OK
                        : (tail.cmd == swaa_pkg::CMD_SAMPLE) ? swaa_pkg::ST_UNKNOWN
                        : swaa_pkg::ST_FULL;
            room_reg   <= found ? tail.room : '0;
            held_reg   <= smp_ok ? tail.cnt[swaa_pkg::HELD_W-1:0] : '0;
            latest_reg <= smp_ok ? tail.newest : '0;
            cold_reg   <= smp_ok && (sum_x < min_prod);
            hot_reg    <= smp_ok && (sum_x > max_prod);
            mask_reg   <= smp_ok;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            average_reg <= mask_reg ? div_q : '0;
        end
    end

    assign out_valid    = (state_reg == S_OUT);
    assign status       = status_reg;
    assign room         = room_reg;
    assign average      = average_reg;
    assign samples_held = held_reg;
    assign too_cold     = cold_reg;
    assign too_hot      = hot_reg;
    assign latest_time  = latest_reg;

`ifndef SYNTHESIS
    a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_vld))
        else $error("more than one item in the cell chain");

    a_tail_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        tail.vld |-> (state_reg == S_CHAIN))
        else $error("chain delivered an item outside the chain phase");

    a_div_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide phase");

    a_no_flags_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != swaa_pkg::ST_OK)) |-> (!too_cold && !too_hot
            && (average == '0)))
        else $error("error result carries sample fields");
`endif

endmodule

// ===== src/swaa_cell.sv =====
// One table entry: sensor id, room, sample window and running sum.
module swaa_cell #(
    parameter int WINDOW = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  swaa_pkg::pkt_t  pkt_in,
    output swaa_pkg::pkt_t  pkt_out
);

    localparam int CW = $clog2(WINDOW + 1);

    logic                                   used_reg;
    logic [swaa_pkg::ID_W-1:0]              sid_reg;
    logic [swaa_pkg::ID_W-1:0]              rid_reg;
    logic [CW-1:0]                          cnt_reg;
    logic [CW-1:0]                          cnt_next;
    logic [swaa_pkg::TS_W-1:0]              newest_reg;
    logic [swaa_pkg::TS_W-1:0]              newest_next;
    logic signed [swaa_pkg::SUM_W-1:0]      sum_reg;
    logic signed [swaa_pkg::SUM_W-1:0]      sum_next;
    logic signed [swaa_pkg::TEMP_W-1:0]     win_reg [WINDOW];
    logic signed [swaa_pkg::TEMP_W-1:0]     win_next [WINDOW];
    logic signed [swaa_pkg::TEMP_W-1:0]     drop;
    swaa_pkg::pkt_t                         pkt_reg;
    swaa_pkg::pkt_t                         pkt_next;
    logic                                   hit_load;
    logic                                   hit_smp;
    logic                                   full;

    assign hit_load = pkt_in.vld && !pkt_in.done && (pkt_in.cmd == swaa_pkg::CMD_LOAD)
                      && !used_reg;
    assign hit_smp  = pkt_in.vld && !pkt_in.done && (pkt_in.cmd == swaa_pkg::CMD_SAMPLE)
                      && used_reg && (sid_reg == pkt_in.sid);
    assign full     = (cnt_reg == CW'(WINDOW));
    assign cnt_next = full ? cnt_reg : cnt_reg + CW'(1);
    assign drop     = full ? win_reg[0] : '0;
    assign sum_next = sum_reg + swaa_pkg::sext_sum(pkt_in.temp) - swaa_pkg::sext_sum(drop);
    assign newest_next = (pkt_in.ts > newest_reg) ? pkt_in.ts : newest_reg;

    // shift out the oldest when full, otherwise append at the fill position
    for (genvar j = 0; j < WINDOW; j++) begin : g_win
        if (j < WINDOW - 1) begin : g_mid
            always_comb
            begin
                if (full)
                begin
                    win_next[j] = win_reg[j+1];
                end
                else if (cnt_reg == CW'(j))
                begin
                    win_next[j] = pkt_in.temp;
                end
                else
                begin
                    win_next[j] = win_reg[j];
                end
            end
        end else begin : g_last
            always_comb
            begin
                if (full || (cnt_reg == CW'(j)))
                begin
                    win_next[j] = pkt_in.temp;
                end
                else
                begin
                    win_next[j] = win_reg[j];
                end
            end
        end
    end

    always_comb
    begin
        pkt_next = pkt_in;
        if (hit_load)
        begin
            pkt_next.done   = 1'b1;
            pkt_next.room   = pkt_in.rid;
            pkt_next.sum    = '0;
            pkt_next.cnt    = '0;
            pkt_next.newest = '0;
        end
        else if (hit_smp)
        begin
            pkt_next.done   = 1'b1;
            pkt_next.room   = rid_reg;
            pkt_next.sum    = sum_next;
            pkt_next.cnt    = swaa_pkg::CNT_W'(cnt_next);
            pkt_next.newest = newest_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg    <= '0;
            used_reg   <= 1'b0;
            cnt_reg    <= '0;
            newest_reg <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
            if (hit_load)
            begin
                used_reg   <= 1'b1;
                cnt_reg    <= '0;
                newest_reg <= '0;
            end
            else if (hit_smp)
            begin
                cnt_reg    <= cnt_next;
                newest_reg <= newest_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_load)
        begin
            sid_reg <= pkt_in.sid;
            rid_reg <= pkt_in.rid;
            sum_reg <= '0;
        end
        else if (hit_smp)
        begin
            sum_reg <= sum_next;
            win_reg <= win_next;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

// ===== src/swaa_div.sv =====
// Restoring divider, one quotient bit a cycle, truncating toward zero.
module swaa_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [swaa_pkg::SUM_W-1:0]  dividend,
    input  logic [swaa_pkg::CNT_W-1:0]         divisor,
    output logic                               done,
    output logic signed [swaa_pkg::TEMP_W-1:0] quotient
);

    localparam int N   = swaa_pkg::SUM_W;
    localparam int CW  = swaa_pkg::CNT_W;
    localparam int STW = $clog2(N);

    logic            busy_reg;
    logic            done_reg;
    logic [STW-1:0]  step_reg;
    logic [N-1:0]    quo_reg;
    logic [CW-1:0]   rem_reg;
    logic [CW-1:0]   div_reg;
    logic            neg_reg;
    logic [CW:0]     trial;
    logic [CW:0]     diff;
    logic            ge;
    logic [swaa_pkg::TEMP_W-1:0] mag;

    assign trial = {rem_reg, quo_reg[N-1]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};
    assign mag   = quo_reg[swaa_pkg::TEMP_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STW'(1);
                if (step_reg == STW'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[N-1] ? N'(-dividend) : N'(dividend);
            neg_reg <= dividend[N-1];
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N-2:0], ge};
            rem_reg <= ge ? diff[CW-1:0] : trial[CW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag) : $signed(mag);

endmodule

// ===== tb/swaa_checker.sv =====
// Checker: watches the input, result and register channels, predicts and compares results.
`timescale 1ns / 100ps
module swaa_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               cmd,
    input  logic [swaa_pkg::ID_W-1:0]          sensor,
    input  logic [swaa_pkg::ID_W-1:0]          room_id,
    input  logic signed [swaa_pkg::TEMP_W-1:0] temperature,
    input  logic [swaa_pkg::TS_W-1:0]          timestamp,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [1:0]                         status,
    input  logic [swaa_pkg::ID_W-1:0]          room,
    input  logic signed [swaa_pkg::TEMP_W-1:0] average,
    input  logic [swaa_pkg::HELD_W-1:0]        samples_held,
    input  logic                               too_cold,
    input  logic                               too_hot,
    input  logic [swaa_pkg::TS_W-1:0]          latest_time,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [swaa_pkg::TEMP_W-1:0]        cfg_data,
    output int                                 fail_count,
    output int                                 pending
);
    localparam int TABLE_DEPTH = 16;
    localparam int WIN_LEN     = 5;

    typedef struct packed {
        logic [1:0]                         status;
        logic [swaa_pkg::ID_W-1:0]          room;
        logic signed [swaa_pkg::TEMP_W-1:0] average;
        logic [swaa_pkg::HELD_W-1:0]        held;
        logic                               cold;
        logic                               hot;
        logic [swaa_pkg::TS_W-1:0]          latest;
    } reading_t;

    reading_t                           expected_readings[$];
    logic signed [swaa_pkg::TEMP_W-1:0] lo_limit, hi_limit;
    logic [swaa_pkg::ID_W-1:0]          ids[TABLE_DEPTH];
    logic [swaa_pkg::ID_W-1:0]          rooms[TABLE_DEPTH];
    logic signed [swaa_pkg::TEMP_W-1:0] window[TABLE_DEPTH][WIN_LEN];
    int                                 counts[TABLE_DEPTH];
    logic [swaa_pkg::TS_W-1:0]          newest[TABLE_DEPTH];
    int                                 used;

    assign pending = expected_readings.size();

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic reading_t predict_reading(input logic c,
                                                 input logic [swaa_pkg::ID_W-1:0] sid,
                                                 input logic [swaa_pkg::ID_W-1:0] rid,
                                                 input logic signed [swaa_pkg::TEMP_W-1:0] t,
                                                 input logic [swaa_pkg::TS_W-1:0] ts);
        reading_t r;
        int       e;
        longint   sum;
        r = '0;
        e = -1;
        if (c == swaa_pkg::CMD_LOAD) begin
            if (used >= TABLE_DEPTH)
            begin
                r.status = swaa_pkg::ST_FULL;
                return r;
            end
            ids[used] = sid;
            rooms[used] = rid;
            counts[used] = 0;
            newest[used] = '0;
            used++;
            r.room = rid;
            return r;
        end
        for (int i = used - 1; i >= 0; i--)
            if (ids[i] == sid)
                e = i;
        if (e < 0)
        begin
            r.status = swaa_pkg::ST_UNKNOWN;
            return r;
        end
        if (counts[e] < WIN_LEN)
        begin
            window[e][counts[e]] = t;
            counts[e]++;
        end
        else
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
                window[e][i] = window[e][i + 1];
            window[e][WIN_LEN - 1] = t;
        end
        sum = 0;
        for (int i = 0; i < counts[e]; i++)
            sum += window[e][i];
        if (ts > newest[e])
            newest[e] = ts;
        r.room    = rooms[e];
        r.average = swaa_pkg::TEMP_W'(sum / counts[e]);
        r.held    = swaa_pkg::HELD_W'(counts[e]);
        r.cold    = sum < longint'(lo_limit) * counts[e];
        r.hot     = sum > longint'(hi_limit) * counts[e];
        r.latest  = newest[e];
        return r;
    endfunction

    always @(posedge clk)
    begin
        reading_t w;
        if (!rst_n)
        begin
            lo_limit = '0;
            hi_limit = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == swaa_pkg::REG_MIN_TEMP)
                    lo_limit = cfg_data;
                else
                    hi_limit = cfg_data;
            end
            if (in_valid && !in_stall)
                expected_readings.push_back(predict_reading(cmd, sensor, room_id,
                                                            temperature, timestamp));
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    report("unexpected result", 1, 0);
                end
                else
                begin
                    w = expected_readings.pop_front();
                    if (status != w.status) report("status", status, w.status);
                    if (room != w.room) report("room", room, w.room);
                    if (average != w.average) report("average", average, w.average);
                    if (samples_held != w.held) report("samples_held", samples_held, w.held);
                    if (too_cold != w.cold) report("too_cold", too_cold, w.cold);
                    if (too_hot != w.hot) report("too_hot", too_hot, w.hot);
                    if (latest_time != w.latest)
                        report("latest_time", latest_time, w.latest);
                end
            end
        end
    end
endmodule

// ===== tb/tb_sensor_window_average_alarm_core.sv =====
// Testbench top: clock, reset, stimulus, register writes and final verdict.
`timescale 1ns / 100ps
module tb_sensor_window_average_alarm_core;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic                               cmd = swaa_pkg::CMD_LOAD;
    logic [swaa_pkg::ID_W-1:0]          sensor = '0;
    logic [swaa_pkg::ID_W-1:0]          room_id = '0;
    logic signed [swaa_pkg::TEMP_W-1:0] temperature = '0;
    logic [swaa_pkg::TS_W-1:0]          timestamp = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [1:0]                         status;
    logic [swaa_pkg::ID_W-1:0]          room;
    logic signed [swaa_pkg::TEMP_W-1:0] average;
    logic [swaa_pkg::HELD_W-1:0]        samples_held;
    logic                               too_cold, too_hot;
    logic [swaa_pkg::TS_W-1:0]          latest_time;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic                               cfg_index = swaa_pkg::REG_MIN_TEMP;
    logic [swaa_pkg::TEMP_W-1:0]        cfg_data = '0;
    int                                 fail_count, pending;
    int                                 out_wait = 0;
    logic [swaa_pkg::ID_W-1:0]          known_ids[$];

    always #4 clk = ~clk;

    sensor_window_average_alarm_core DUT (.*);
    swaa_checker u_checker (.*);

    // hold each result for a drawn number of cycles before taking it
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            out_wait = $urandom_range(0, 5);
        else if (out_valid && out_wait != 0)
            out_wait--;
        out_stall <= (out_wait != 0);
    end

    task automatic write_limit(input logic idx, input logic [swaa_pkg::TEMP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic c, input logic [swaa_pkg::ID_W-1:0] sid,
                             input logic [swaa_pkg::ID_W-1:0] rid,
                             input logic [swaa_pkg::TEMP_W-1:0] t,
                             input logic [swaa_pkg::TS_W-1:0] ts);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        sensor      <= sid;
        room_id     <= rid;
        temperature <= t;
        timestamp   <= ts;
        do @(posedge clk); while (in_stall);
        if (c == swaa_pkg::CMD_LOAD)
            known_ids.push_back(sid);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic random_items(input int n);
        logic [swaa_pkg::ID_W-1:0] sid;
        for (int k = 0; k < n; k++)
        begin
            if (known_ids.size() < 16 && $urandom_range(0, 9) == 0)
                send_item(swaa_pkg::CMD_LOAD, swaa_pkg::ID_W'($urandom_range(0, 40)),
                          swaa_pkg::ID_W'($urandom), 0, 0);
            else
            begin
                if (known_ids.size() != 0 && $urandom_range(0, 9) != 0)
                    sid = known_ids[$urandom_range(0, known_ids.size() - 1)];
                else
                    sid = swaa_pkg::ID_W'($urandom);
                if ($urandom_range(0, 3) == 0)
                    send_item(swaa_pkg::CMD_SAMPLE, sid, swaa_pkg::ID_W'($urandom),
                              swaa_pkg::TEMP_W'($urandom), $urandom);
                else
                    send_item(swaa_pkg::CMD_SAMPLE, sid, swaa_pkg::ID_W'($urandom),
                              swaa_pkg::TEMP_W'($urandom_range(0, 12000) - 6000),
                              $urandom_range(0, 100000));
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, unknown id, duplicate id, window wrap
        send_item(swaa_pkg::CMD_SAMPLE, 16'h1234, 0, 0, 0);
        send_item(swaa_pkg::CMD_LOAD, 16'h0000, 16'hFFFF, 0, 0);
        send_item(swaa_pkg::CMD_LOAD, 16'hFFFF, 16'h0000, 0, 0);
        send_item(swaa_pkg::CMD_LOAD, 16'h0000, 16'h5555, 0, 0);
        send_item(swaa_pkg::CMD_SAMPLE, 16'hFFFF, 0, 16'sh7FFF, 32'hFFFF_FFFF);
        send_item(swaa_pkg::CMD_SAMPLE, 16'hFFFF, 0, 16'sh8000, 32'd5);
        for (int k = 0; k < 7; k++)
            send_item(swaa_pkg::CMD_SAMPLE, 16'h0000, 16'hFFFF,
                      (k % 2) ? 16'h8000 : 16'h7FFF, swaa_pkg::TS_W'(k * 7));
        send_item(swaa_pkg::CMD_SAMPLE, 16'h0000, 0, -16'sd3, 32'hAAAA_5555);
        drain();
        write_limit(swaa_pkg::REG_MIN_TEMP, 16'h8000);
        write_limit(swaa_pkg::REG_MAX_TEMP, 16'h7FFF);
        random_items(130);
        drain();
        write_limit(swaa_pkg::REG_MIN_TEMP, 16'hF000);
        write_limit(swaa_pkg::REG_MAX_TEMP, 16'h1000);
        random_items(130);
        drain();
        write_limit(swaa_pkg::REG_MIN_TEMP, 16'h7FFF);
        write_limit(swaa_pkg::REG_MAX_TEMP, 16'h8000);
        random_items(100);
        // fill the table until it reports full
        for (int k = 0; k < 18; k++)
            send_item(swaa_pkg::CMD_LOAD, swaa_pkg::ID_W'(16'h4000 + k), 16'hA5A5, 0, 0);
        drain();
        if (fail_count == 0)
            $display("** sensor_window_average_alarm_core: PASSED **");
        else
            $display("** sensor_window_average_alarm_core: FAILED **");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("** sensor_window_average_alarm_core: FAILED **");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/swaa_pkg.sv
src/swaa_cell.sv
src/swaa_div.sv
src/sensor_window_average_alarm_core.sv
tb/swaa_checker.sv
tb/tb_sensor_window_average_alarm_core.sv
